### src/tllf_pkg.sv
// Shared types and constants for the tree leaf LCA finder.
package tllf_pkg;

    // Width of one row-table entry: max first-seen and previous leaf, 11 bits each.
    localparam int ROW_W = 22;

    // Leaf classification codes.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_LATER = 2'd2;

    // The "no node" value used in tables and results.
    localparam logic signed [10:0] LCA_NONE = -11'sd1;

    // Input commands.
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    // One input beat.
    typedef struct packed {
        logic       cmd;
        logic [9:0] row_index;
        logic [9:0] col_index;
        logic [9:0] first_of_col;
        logic [9:0] link_value;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic signed [10:0] lca;
        logic [1:0]         leaf_kind;
    } t_out;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_FIND,
        ST_COMP,
        ST_DONE
    } t_state;

endpackage

### src/tllf_ram.sv
// Synchronous single-write, single-read memory with registered, write-first read data.
module tllf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tllf_seq.sv
// Sequencer: table clearing, leaf test, root walk and path compression.
module tllf_seq
    import tllf_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_res_valid,
    input  logic                     i_res_take,
    output t_out                     o_res,
    output logic                     o_row_we,
    output logic [$clog2(NODES)-1:0] o_row_waddr,
    output logic [ROW_W-1:0]         o_row_wdata,
    output logic [$clog2(NODES)-1:0] o_row_raddr,
    input  logic [ROW_W-1:0]         i_row_rdata,
    output logic                     o_link_we,
    output logic [$clog2(NODES)-1:0] o_link_waddr,
    output logic [$clog2(NODES)-1:0] o_link_wdata,
    output logic [$clog2(NODES)-1:0] o_link_raddr,
    input  logic [$clog2(NODES)-1:0] i_link_rdata
);

    localparam int AW   = $clog2(NODES);
    localparam int CNTW = $clog2(NODES + 1);

    t_state          r_state, n_state;
    t_in             r_item, n_item;
    logic [AW-1:0]   r_q, n_q;
    logic [AW-1:0]   r_start, n_start;
    logic [AW-1:0]   r_root, n_root;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [AW-1:0]   r_clr, n_clr;
    t_out            r_res, n_res;

    logic signed [10:0] rd_mfs;
    logic signed [10:0] rd_prev;
    logic               prev_none;
    logic               row_ok, col_ok, link_ok;
    logic               is_leaf;
    logic [AW-1:0]      up;
    logic [CNTW-1:0]    cnt_inc;
    logic               find_stop;
    logic [AW-1:0]      root_f;
    logic               comp_last;
    logic               clr_last;

    // Row table read data and the leaf test.
    assign rd_mfs    = $signed(i_row_rdata[ROW_W-1:11]);
    assign rd_prev   = $signed(i_row_rdata[10:0]);
    assign prev_none = rd_prev[10];
    assign row_ok    = 32'(r_item.row_index) < NODES;
    assign col_ok    = 32'(r_item.col_index) < NODES;
    assign link_ok   = 32'(r_item.link_value) < NODES;
    assign is_leaf   = (r_item.cmd == CMD_QUERY) && row_ok && col_ok
                       && (r_item.row_index > r_item.col_index)
                       && ($signed({1'b0, r_item.first_of_col}) > rd_mfs);

    // Walk step: one link read per cycle, capped at NODES steps.
    assign up        = i_link_rdata;
    assign cnt_inc   = r_cnt + CNTW'(1);
    assign find_stop = (up == r_q) || (cnt_inc == CNTW'(NODES));
    assign root_f    = (up == r_q) ? r_q : up;
    assign comp_last = (cnt_inc == CNTW'(NODES)) || (up == r_root);
    assign clr_last  = (r_clr == AW'(NODES - 1));

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_q     <= n_q;
        r_start <= n_start;
        r_root  <= n_root;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (is_leaf && !prev_none) begin
                    n_state = ST_FIND;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FIND: begin
                if (find_stop) begin
                    n_state = (r_start == root_f) ? ST_DONE : ST_COMP;
                end
            end
            ST_COMP: begin
                if (comp_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_item       = r_item;
        n_q          = r_q;
        n_start      = r_start;
        n_root       = r_root;
        n_cnt        = r_cnt;
        n_clr        = r_clr;
        n_res        = r_res;
        o_row_we     = 1'b0;
        o_row_waddr  = AW'(r_item.row_index);
        o_row_wdata  = {1'b0, r_item.first_of_col, 1'b0, r_item.col_index};
        o_row_raddr  = AW'(i_in.row_index);
        o_link_we    = 1'b0;
        o_link_waddr = r_q;
        o_link_wdata = r_root;
        o_link_raddr = up;
        case (r_state)
            ST_CLEAR: begin
                // Sweep all tables back to their reset contents.
                o_row_we     = 1'b1;
                o_row_waddr  = r_clr;
                o_row_wdata  = {LCA_NONE, LCA_NONE};
                o_link_we    = 1'b1;
                o_link_waddr = r_clr;
                o_link_wdata = r_clr;
                n_clr        = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                end
            end
            ST_ROW: begin
                n_res = '{lca: LCA_NONE, leaf_kind: KIND_NONE};
                if (r_item.cmd == CMD_SET) begin
                    o_link_we    = col_ok && link_ok;
                    o_link_waddr = AW'(r_item.col_index);
                    o_link_wdata = AW'(r_item.link_value);
                end else if (is_leaf) begin
                    o_row_we = 1'b1;
                    if (prev_none) begin
                        n_res = '{lca: $signed({1'b0, r_item.row_index}),
                                  leaf_kind: KIND_FIRST};
                    end else begin
                        // Start the root walk at the previous leaf.
                        n_q          = AW'(rd_prev[9:0]);
                        n_start      = AW'(rd_prev[9:0]);
                        n_cnt        = '0;
                        o_link_raddr = AW'(rd_prev[9:0]);
                    end
                end
            end
            ST_FIND: begin
                if (!find_stop) begin
                    n_q   = up;
                    n_cnt = cnt_inc;
                end else begin
                    n_root = root_f;
                    n_res  = '{lca: $signed(11'(root_f)), leaf_kind: KIND_LATER};
                    // Restart at the previous leaf for the compression pass.
                    o_link_raddr = r_start;
                    n_q          = r_start;
                    n_cnt        = '0;
                end
            end
            ST_COMP: begin
                // Relink the current node to the root and step on.
                o_link_we = 1'b1;
                n_q       = up;
                n_cnt     = cnt_inc;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

### src/tree_leaf_lca_finder.sv
// Top level of the tree leaf LCA finder: tables, sequencer and output register.
//
//  Channel | Signals                         | Beat
//  --------+---------------------------------+-----------------------------------
//  input   | i_in_valid, o_in_ready, i_in    | command: leaf query or link write
//  output  | o_out_valid, i_out_ready, o_out | lca and leaf kind, one per command
//
// A link write, a non-leaf query and a first leaf pass from acceptance through
// ST_ROW to ST_DONE, where the result waits to enter the output register.
// A later leaf adds the root walk, one link read per step, and path compression,
// one node relinked per step, each bounded by NODES steps; the single link-table
// read port sets this pace.
// After reset all NODES table entries are swept before the first beat is taken.
// One command is worked on at a time; a result waiting in the output register
// only holds the sequencer if the next result is ready before it is taken.
module tree_leaf_lca_finder
    import tllf_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int AW = $clog2(NODES);

    logic          res_valid;
    logic          res_take;
    t_out          res;
    logic          row_we;
    logic [AW-1:0] row_waddr;
    logic [ROW_W-1:0] row_wdata;
    logic [AW-1:0] row_raddr;
    logic [ROW_W-1:0] row_rdata;
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [AW-1:0] link_wdata;
    logic [AW-1:0] link_raddr;
    logic [AW-1:0] link_rdata;
    logic          r_out_valid;
    t_out          r_out;

    // Row table: max first-seen and previous leaf per node.
    tllf_ram #(
        .DEPTH(NODES),
        .WIDTH(ROW_W)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(row_waddr),
        .i_wdata(row_wdata),
        .i_raddr(row_raddr),
        .o_rdata(row_rdata)
    );

    // Ancestor link table.
    tllf_ram #(
        .DEPTH(NODES),
        .WIDTH(AW)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(link_raddr),
        .o_rdata(link_rdata)
    );

    tllf_seq #(
        .NODES(NODES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_row_we    (row_we),
        .o_row_waddr (row_waddr),
        .o_row_wdata (row_wdata),
        .o_row_raddr (row_raddr),
        .i_row_rdata (row_rdata),
        .o_link_we   (link_we),
        .o_link_waddr(link_waddr),
        .o_link_wdata(link_wdata),
        .o_link_raddr(link_raddr),
        .i_link_rdata(link_rdata)
    );

    // Output register: loads when empty or when its beat is taken.
    assign res_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the tree leaf LCA finder: directed and random beats.
`timescale 1ns / 100ps

module tb_top;
    import tllf_pkg::*;

    localparam int NODES_N         = 1024;
    localparam int POOL            = 64;     // Most well-formed traffic stays in this node range.
    localparam int RANDOM_BEATS    = 700;
    localparam int PRESSURE_AT     = 200;    // Result count at which the long hold-off starts.
    localparam int PRESSURE_CYCLES = 300;
    localparam int STALL_LIMIT     = 20000;  // Covers the clearing sweep and the longest walks.
    localparam int TAIL_CYCLES     = 40;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_beat  = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // Predictor tables: best first-descendant seen per row, last leaf per row, ancestor links.
    logic signed [10:0] seen_first [NODES_N];
    logic signed [10:0] last_leaf  [NODES_N];
    logic [9:0]         up_link    [NODES_N];

    t_in  beats_to_send[$];
    t_out lca_results_due[$];
    int   gen_first [NODES_N];
    int   beats_total;
    int   results_seen = 0;
    int   fail_count   = 0;
    int   idle_cycles  = 0;
    int   calm_in      = 0;
    int   calm_out     = 0;
    int   in_wait      = 0;
    int   out_wait     = 0;
    int   hold_left    = 0;

    tree_leaf_lca_finder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    // Works out the result of one accepted beat and updates the predictor tables.
    function automatic t_out leaf_lca_of(input t_in b);
        t_out               r;
        logic signed [10:0] prev;
        logic [9:0]         root;
        logic [9:0]         hop;
        logic [9:0]         up;
        int                 k;
        r.lca       = LCA_NONE;
        r.leaf_kind = KIND_NONE;
        if (b.cmd == CMD_SET) begin
            up_link[b.col_index] = b.link_value;
            return r;
        end
        if (b.row_index <= b.col_index ||
            $signed({1'b0, b.first_of_col}) <= seen_first[b.row_index]) begin
            return r;
        end
        seen_first[b.row_index] = $signed({1'b0, b.first_of_col});
        prev = last_leaf[b.row_index];
        last_leaf[b.row_index] = $signed({1'b0, b.col_index});
        if (prev < 0) begin
            r.lca       = $signed({1'b0, b.row_index});
            r.leaf_kind = KIND_FIRST;
            return r;
        end
        // Root walk, cut short after one pass over all nodes when links form a cycle.
        root = prev[9:0];
        for (k = 0; k < NODES_N; k++) begin
            if (up_link[root] == root) break;
            root = up_link[root];
        end
        // Relink every node on the path straight to the root.
        hop = prev[9:0];
        for (k = 0; k < NODES_N && hop != root; k++) begin
            up = up_link[hop];
            up_link[hop] = root;
            hop = up;
        end
        r.lca       = $signed({1'b0, root});
        r.leaf_kind = KIND_LATER;
        return r;
    endfunction

    // Idle cycles before the next beat; calm runs give back-to-back stretches.
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic push_beat(input logic c, input int r, input int col, input int f,
                             input int l);
        t_in b;
        b.cmd          = c;
        b.row_index    = r[9:0];
        b.col_index    = col[9:0];
        b.first_of_col = f[9:0];
        b.link_value   = l[9:0];
        beats_to_send.push_back(b);
    endtask

    // Sender: presents queued beats after a drawn gap and predicts each accepted one.
    always @(posedge i_clk) begin : p_drive
        logic nxt_valid;
        t_in  nxt_beat;
        nxt_valid = in_valid;
        nxt_beat  = in_beat;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                lca_results_due.push_back(leaf_lca_of(in_beat));
                nxt_valid = 1'b0;
                in_wait   = draw_wait(calm_in);
            end
            if (!nxt_valid) begin
                if (in_wait > 0) begin
                    in_wait--;
                end else if (beats_to_send.size() != 0) begin
                    nxt_beat  = beats_to_send.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        in_valid <= nxt_valid;
        in_beat  <= nxt_beat;
    end

    // Receiver: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin : p_monitor
        t_out due;
        logic nxt_ready;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (lca_results_due.size() == 0) begin
                    $error("result beat with nothing expected: lca %0d, leaf_kind %0d",
                           o_out.lca, o_out.leaf_kind);
                    fail_count++;
                end else begin
                    due = lca_results_due.pop_front();
                    if (due.lca !== o_out.lca) begin
                        $error("lca mismatch: expected %0d, actual %0d", due.lca, o_out.lca);
                        fail_count++;
                    end
                    if (due.leaf_kind !== o_out.leaf_kind) begin
                        $error("leaf_kind mismatch: expected %0d, actual %0d",
                               due.leaf_kind, o_out.leaf_kind);
                        fail_count++;
                    end
                end
                out_wait = draw_wait(calm_out);
                if (results_seen == PRESSURE_AT) hold_left = PRESSURE_CYCLES;
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (out_wait > 0) begin
                out_wait--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        out_ready <= nxt_ready;
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : p_main
        int base;
        int sel;
        int row;
        int col;
        int first;
        int node;
        int hi;
        int len;
        int n;

        for (n = 0; n < NODES_N; n++) begin
            seen_first[n] = LCA_NONE;
            last_leaf[n]  = LCA_NONE;
            up_link[n]    = n[9:0];
            gen_first[n]  = -1;
        end

        // Directed: first leaf, repeated first, row not above column, later leaf.
        push_beat(CMD_QUERY, 5, 3, 0, 0);
        push_beat(CMD_QUERY, 5, 4, 0, 0);
        push_beat(CMD_QUERY, 3, 5, 9, 0);
        push_beat(CMD_QUERY, 6, 6, 9, 0);
        push_beat(CMD_SET, 0, 3, 0, 7);
        push_beat(CMD_SET, 0, 7, 0, 9);
        push_beat(CMD_QUERY, 5, 4, 2, 0);
        push_beat(CMD_QUERY, 5, 2, 4, 0);
        // Extremes of the node and first-descendant fields.
        push_beat(CMD_QUERY, 1023, 0, 1023, 0);
        push_beat(CMD_QUERY, 1023, 1022, 1023, 1023);
        push_beat(CMD_QUERY, 1023, 1, 0, 0);
        push_beat(CMD_QUERY, 0, 0, 0, 1023);
        push_beat(CMD_SET, 1023, 1023, 1023, 1023);
        push_beat(CMD_SET, 0, 0, 0, 0);
        // A link cycle: the root walk has to give up after one pass over all nodes.
        push_beat(CMD_SET, 0, 10, 0, 11);
        push_beat(CMD_SET, 0, 11, 0, 10);
        push_beat(CMD_SET, 0, 12, 0, 10);
        push_beat(CMD_QUERY, 20, 12, 0, 0);
        push_beat(CMD_QUERY, 20, 13, 1, 0);
        push_beat(CMD_QUERY, 20, 14, 2, 0);
        push_beat(CMD_SET, 0, 10, 0, 10);
        push_beat(CMD_SET, 0, 11, 0, 11);
        push_beat(CMD_SET, 0, 12, 0, 12);

        // Random: mostly leaf query runs per row and upward links, with some noise.
        // Links never point below their node, so no cycle forms here.
        base = beats_to_send.size();
        while (beats_to_send.size() < base + RANDOM_BEATS) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                col = $urandom_range(0, 1023);
                if ($urandom_range(0, 1) == 1) begin
                    push_beat(CMD_SET, $urandom_range(0, 1023), col, $urandom_range(0, 1023),
                              $urandom_range(col, 1023));
                end else begin
                    push_beat(CMD_QUERY, $urandom_range(0, 1023), col,
                              $urandom_range(0, 1023), $urandom_range(0, 1023));
                end
            end else if (sel < 40) begin
                node = $urandom_range(0, POOL - 2);
                hi   = (node + 6 > POOL - 1) ? POOL - 1 : node + 6;
                push_beat(CMD_SET, $urandom_range(0, 1023), node, $urandom_range(0, 1023),
                          ($urandom_range(0, 5) == 0) ? node : $urandom_range(node + 1, hi));
            end else begin
                row = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1023)
                                                   : $urandom_range(1, POOL - 1);
                len = $urandom_range(1, 5);
                for (n = 0; n < len; n++) begin
                    col = $urandom_range(0, row - 1);
                    if ($urandom_range(0, 7) == 0) begin
                        // Broken step: a stale first-descendant number or a column too high.
                        if ($urandom_range(0, 1) == 0) begin
                            first = (gen_first[row] < 0) ? 0 : gen_first[row];
                        end else begin
                            col   = row + $urandom_range(0, 3);
                            col   = (col > 1023) ? 1023 : col;
                            first = gen_first[row] + 1;
                        end
                    end else begin
                        first = gen_first[row] + $urandom_range(1, 3);
                    end
                    first = (first > 1023) ? 1023 : first;
                    if (first > gen_first[row]) gen_first[row] = first;
                    push_beat(CMD_QUERY, row, col, first, $urandom_range(0, 1023));
                end
            end
        end
        beats_total = beats_to_send.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every beat gives exactly one result.
        while (results_seen < beats_total) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && lca_results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
src/tllf_pkg.sv
src/tllf_ram.sv
src/tllf_seq.sv
src/tree_leaf_lca_finder.sv
sim/tb_top.sv
